[hdl/tlbmau_pkg.sv]
`default_nettype none
package tlbmau_pkg;

  // geometry
  localparam int ADDR_W       = 32;
  localparam int TLB_ENTRIES  = 256;
  localparam int PAGE_BITS    = 12;
  localparam int SDRAM_BYTES  = 1048576;
  localparam int FB_BYTES     = 262144;

  localparam int IDX_W        = $clog2(TLB_ENTRIES);
  localparam int PAGE_W       = ADDR_W - PAGE_BITS;

  // byte stores are split into four byte lanes, one row holds one byte per lane
  localparam int LANES        = 4;
  localparam int LANE_W       = 2;
  localparam int SD_OFF_W     = $clog2(SDRAM_BYTES);
  localparam int FB_OFF_W     = $clog2(FB_BYTES);
  localparam int SD_ROW_W     = SD_OFF_W - LANE_W;
  localparam int FB_ROW_W     = FB_OFF_W - LANE_W;
  localparam int SD_ROWS      = SDRAM_BYTES / LANES;
  localparam int FB_ROWS      = FB_BYTES / LANES;
  localparam int CLR_ROWS     = (SD_ROWS > FB_ROWS) ? SD_ROWS : FB_ROWS;
  localparam int CLR_W        = $clog2(CLR_ROWS);

  // register reset values
  localparam logic [ADDR_W-1:0] SD_BASE_RST = 32'h1000_0000;
  localparam logic [ADDR_W-1:0] FB_BASE_RST = 32'h2000_0000;

  // largest byte count of one access
  localparam logic [2:0] MAX_COUNT = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_CROSS    = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [0:0] CFG_SDRAM_BASE = 1'b0;
  localparam logic [0:0] CFG_FB_BASE    = 1'b1;

  // region codes
  localparam logic REGION_SDRAM = 1'b0;
  localparam logic REGION_FB    = 1'b1;

  // access kind
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [31:0]       write_data;
    logic [2:0]        byte_count;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_data;
    logic        tlb_hit;
  } out_word_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              region;
  } tlb_entry_t;

endpackage
`default_nettype wire

[hdl/tlb_memory_access_unit.sv]
// an accepted input word passes the lookup, access and result states, and its result word is
//   loaded into the output register when the output is not stalled; in_stall stays high until
//   that load; the tlb memory and the byte-lane memories have registered read ports
// reset: synchronous, active low; tlb valid bits clear at once, then a clearing pass
//   zeroes the byte stores one row a cycle, during which in_stall is high
`default_nettype none
module tlb_memory_access_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tlbmau_pkg::in_word_t  in_word,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tlbmau_pkg::out_word_t      out_word,
  // configuration port
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [31:0]           cfg_wdata
);

  localparam int ADDR_W    = tlbmau_pkg::ADDR_W;
  localparam int PAGE_BITS = tlbmau_pkg::PAGE_BITS;
  localparam int IDX_W     = tlbmau_pkg::IDX_W;
  localparam int PAGE_W    = tlbmau_pkg::PAGE_W;
  localparam int LANES     = tlbmau_pkg::LANES;
  localparam int LANE_W    = tlbmau_pkg::LANE_W;
  localparam int SD_OFF_W  = tlbmau_pkg::SD_OFF_W;
  localparam int FB_OFF_W  = tlbmau_pkg::FB_OFF_W;
  localparam int SD_ROW_W  = tlbmau_pkg::SD_ROW_W;
  localparam int FB_ROW_W  = tlbmau_pkg::FB_ROW_W;
  localparam int SD_ROWS   = tlbmau_pkg::SD_ROWS;
  localparam int FB_ROWS   = tlbmau_pkg::FB_ROWS;
  localparam int CLR_W     = tlbmau_pkg::CLR_W;
  localparam int CLR_ROWS  = tlbmau_pkg::CLR_ROWS;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_ACCESS = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CLR_W-1:0]        clr_cnt_r;
  logic [ADDR_W-1:0]       sd_base_r, fb_base_r;

  // held input word
  tlbmau_pkg::in_word_t    item_r;
  logic                    in_accept;

  // tlb storage: valid bits in flops, page and region in a memory
  logic [tlbmau_pkg::TLB_ENTRIES-1:0] valid_r;
  tlbmau_pkg::tlb_entry_t  tlb_mem [tlbmau_pkg::TLB_ENTRIES];
  tlbmau_pkg::tlb_entry_t  tlb_q;

  // lookup stage results
  logic [IDX_W-1:0]        in_idx, item_idx;
  logic [PAGE_W-1:0]       item_page;
  logic                    lk_hit, lk_sd_in, lk_fb_in, lk_mapped, lk_region, lk_cross;
  logic [ADDR_W:0]         sd_diff, fb_diff;
  logic [2:0]              lk_cnt, lk_cnt_m1;
  logic [ADDR_W-1:0]       lk_last;
  logic                    tlb_we;

  logic                    hit_r, region_r, go_r;
  tlbmau_pkg::status_t     status_r;
  logic [2:0]              cnt_r;
  logic [LANE_W-1:0]       off_lo_r;
  logic [SD_ROW_W-1:0]     sd_row_r;
  logic [FB_ROW_W-1:0]     fb_row_r;

  // byte lane read data
  logic [7:0]              sd_q [LANES];
  logic [7:0]              fb_q [LANES];

  // result register
  logic                    out_valid_r;
  tlbmau_pkg::out_word_t   out_r;
  logic                    out_load;
  logic [31:0]             rd_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // tlb index of the arriving word and of the held word
  assign in_idx    = in_word.address[PAGE_BITS +: IDX_W];
  assign item_idx  = item_r.address[PAGE_BITS +: IDX_W];
  assign item_page = item_r.address[ADDR_W-1:PAGE_BITS];

  // lookup: tlb compare, window decode, page crossing
  always_comb begin
    lk_hit    = valid_r[item_idx] && (tlb_q.page == item_page);
    sd_diff   = {1'b0, item_r.address} - {1'b0, sd_base_r};
    fb_diff   = {1'b0, item_r.address} - {1'b0, fb_base_r};
    lk_sd_in  = !sd_diff[ADDR_W] && (sd_diff[ADDR_W-1:SD_OFF_W] == '0);
    lk_fb_in  = !fb_diff[ADDR_W] && (fb_diff[ADDR_W-1:FB_OFF_W] == '0);
    lk_mapped = lk_hit || lk_sd_in || lk_fb_in;
    if (lk_hit) begin
      lk_region = tlb_q.region;
    end else if (lk_sd_in) begin
      lk_region = tlbmau_pkg::REGION_SDRAM;
    end else begin
      lk_region = tlbmau_pkg::REGION_FB;
    end
    lk_cnt    = (item_r.byte_count > tlbmau_pkg::MAX_COUNT) ? tlbmau_pkg::MAX_COUNT
                                                            : item_r.byte_count;
    lk_cnt_m1 = lk_cnt - 3'd1;
    lk_last   = item_r.address + {{(ADDR_W-3){1'b0}}, lk_cnt_m1};
    lk_cross  = (lk_cnt != 3'd0) && (lk_last[ADDR_W-1:PAGE_BITS] != item_page);
    tlb_we    = (state_r == S_LOOKUP) && lk_mapped && !lk_hit;
  end

  // tlb memory: fill on a mapped miss, read on accept
  always_ff @(posedge clk) begin
    if (tlb_we) begin
      tlb_mem[item_idx] <= '{page: item_page, region: lk_region};
    end
    if (in_accept) begin
      tlb_q <= tlb_mem[in_idx];
    end
  end

  // lookup results for the access stage
  always_ff @(posedge clk) begin
    if (state_r == S_LOOKUP) begin
      hit_r    <= lk_hit;
      region_r <= lk_region;
      cnt_r    <= lk_cnt;
      go_r     <= lk_mapped && !lk_cross;
      if (!lk_mapped) begin
        status_r <= tlbmau_pkg::ST_UNMAPPED;
      end else if (lk_cross) begin
        status_r <= tlbmau_pkg::ST_CROSS;
      end else begin
        status_r <= tlbmau_pkg::ST_DONE;
      end
      if (lk_region == tlbmau_pkg::REGION_FB) begin
        off_lo_r <= fb_diff[LANE_W-1:0];
      end else begin
        off_lo_r <= sd_diff[LANE_W-1:0];
      end
      sd_row_r <= sd_diff[SD_OFF_W-1:LANE_W];
      fb_row_r <= fb_diff[FB_OFF_W-1:LANE_W];
    end
  end

  // byte lanes: lane k holds the bytes whose store offset is k modulo four
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [7:0]          sd_mem [SD_ROWS];
    logic [7:0]          fb_mem [FB_ROWS];
    logic [LANE_W-1:0]   byte_i;
    logic                lane_on, carry;
    logic [SD_ROW_W-1:0] sd_row;
    logic [FB_ROW_W-1:0] fb_row;
    logic                sd_we, fb_we;
    logic [SD_ROW_W-1:0] sd_waddr;
    logic [FB_ROW_W-1:0] fb_waddr;
    logic [7:0]          wbyte;

    // which byte of the word this lane carries, and its row
    always_comb begin
      byte_i  = LANE_W'(k) - off_lo_r;
      lane_on = go_r && ({1'b0, byte_i} < cnt_r);
      carry   = (LANE_W'(k) < off_lo_r);
      sd_row  = sd_row_r + SD_ROW_W'(carry);
      fb_row  = fb_row_r + FB_ROW_W'(carry);
      wbyte   = item_r.write_data[8*byte_i +: 8];
      if (state_r == S_CLEAR) begin
        sd_we    = 1'b1;
        fb_we    = 1'b1;
        sd_waddr = clr_cnt_r[SD_ROW_W-1:0];
        fb_waddr = clr_cnt_r[FB_ROW_W-1:0];
        wbyte    = 8'h00;
      end else begin
        sd_we    = (state_r == S_ACCESS) && lane_on
                   && (item_r.func == tlbmau_pkg::FUNC_WRITE)
                   && (region_r == tlbmau_pkg::REGION_SDRAM);
        fb_we    = (state_r == S_ACCESS) && lane_on
                   && (item_r.func == tlbmau_pkg::FUNC_WRITE)
                   && (region_r == tlbmau_pkg::REGION_FB);
        sd_waddr = sd_row;
        fb_waddr = fb_row;
      end
    end

    // one write port and one registered read port per lane memory
    always_ff @(posedge clk) begin
      if (sd_we) begin
        sd_mem[sd_waddr] <= wbyte;
      end
      if (fb_we) begin
        fb_mem[fb_waddr] <= wbyte;
      end
      if (state_r == S_ACCESS) begin
        sd_q[k] <= sd_mem[sd_row];
        fb_q[k] <= fb_mem[fb_row];
      end
    end
  end

  // gather read bytes in address order
  always_comb begin
    logic [LANE_W-1:0] lane;
    logic [7:0]        src;
    rd_data = '0;
    for (int i = 0; i < LANES; i++) begin
      lane = off_lo_r + LANE_W'(i);
      src  = (region_r == tlbmau_pkg::REGION_FB) ? fb_q[lane] : sd_q[lane];
      if (go_r && (item_r.func == tlbmau_pkg::FUNC_READ) && (3'(i) < cnt_r)) begin
        rd_data[8*i +: 8] = src;
      end
    end
  end

  assign out_load = (state_r == S_RESULT) && (!out_valid_r || !out_stall);

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.status    <= status_r;
      out_r.read_data <= rd_data;
      out_r.tlb_hit   <= hit_r;
    end
  end

  // held input word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_word;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == CLR_W'(CLR_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: state_nxt = S_ACCESS;
      S_ACCESS: state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      sd_base_r   <= tlbmau_pkg::SD_BASE_RST;
      fb_base_r   <= tlbmau_pkg::FB_BASE_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + CLR_W'(1);
      end
      if (tlb_we) begin
        valid_r[item_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          tlbmau_pkg::CFG_SDRAM_BASE: sd_base_r <= cfg_wdata;
          tlbmau_pkg::CFG_FB_BASE:    fb_base_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire
